// ===== rtl/oaht_pkg.sv =====
`timescale 1ns / 1ps
package oaht_pkg;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned HASH_W  = 32;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned LIMIT_W = 6;
  localparam int unsigned CNT_W   = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd48;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_SET = 2'd0;
  localparam logic [FUNC_W-1:0] FN_GET = 2'd1;
  localparam logic [FUNC_W-1:0] FN_DEL = 2'd2;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_USED  = 2'd1,
    ST_TOMB  = 2'd2
  } slot_stat_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD1,
    S_MOD2,
    S_MOD3,
    S_PROBE
  } state_t;

  // One write command to the slot store
  typedef struct packed {
    logic              stat_we;
    slot_stat_t        stat;
    logic              kd_we;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } slot_wr_t;

endpackage

// ===== rtl/open_addressing_hash_table_top.sv =====
`timescale 1ns / 1ps
// Linear-probing hash table with tombstones, CAPACITY slots.
// Request channel (in_valid/in_ready): func (set, get, delete), key_id,
// key_hash, write_value. Each request yields exactly one response on the
// response channel (out_valid/out_ready): ok, read_value, full_res.
// Configuration channel (cfg_valid/cfg_ready, cfg_data): load_limit,
// always ready; write it only while no request is in flight.
// The first slot read is issued when the request is taken; the probe then
// examines P slots in turn, P the probe length (1 to CAPACITY). With a
// capacity that is not a power of two, the start slot comes from a
// reciprocal multiply through states MOD1, MOD2 and MOD3. The probe walks
// one slot per cycle through the single read port of the slot memories.
// One request is in flight at a time; the next request is taken as soon
// as the previous response sits in the output register.
// Reset: the status memory is swept to empty, one slot a cycle, and
// in_ready stays low until the sweep reaches the last slot.
// Receiver stall: the response register holds; a following request probes
// and then waits with its slot writes held until the register frees.
module open_addressing_hash_table_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [oaht_pkg::FUNC_W-1:0]   func,
  input  logic [oaht_pkg::KEY_W-1:0]    key_id,
  input  logic [oaht_pkg::HASH_W-1:0]   key_hash,
  input  logic [oaht_pkg::DATA_W-1:0]   write_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          ok,
  output logic [oaht_pkg::DATA_W-1:0]   read_value,
  output logic                          full_res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [oaht_pkg::LIMIT_W-1:0]  cfg_data
);
  import oaht_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(CAPACITY - 1);
  localparam bit IS_POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);
  // floor(2^32 / CAPACITY) for the start-slot reduction
  localparam logic [HASH_W-1:0] RECIP = HASH_W'((64'd1 << 32) / 64'(CAPACITY));
  localparam logic [HASH_W-1:0] CAP32 = HASH_W'(CAPACITY);
  localparam logic [HASH_W-1:0] CAP2X = HASH_W'(2 * CAPACITY);

  state_t state, state_next;

  // Request registers
  logic [FUNC_W-1:0]  op;
  logic [KEY_W-1:0]   key;
  logic [DATA_W-1:0]  wval;
  logic [HASH_W-1:0]  hash_r;

  // Start-slot reduction
  logic [HASH_W-1:0]  mq;
  logic [HASH_W-1:0]  mp;
  logic [HASH_W-1:0]  mod_diff;
  logic [HASH_W-1:0]  mod_rem;

  // Probe walk
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   idx_inc;
  logic [IDX_W-1:0]   n;
  logic               tomb_found;
  logic [IDX_W-1:0]   tomb_idx;
  logic [IDX_W-1:0]   clr_idx;

  logic [CNT_W-1:0]   cnt;
  logic [LIMIT_W-1:0] load_limit;

  // Slot store
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  slot_wr_t           wr;
  slot_stat_t         rd_stat;
  logic [KEY_W-1:0]   rd_key;
  logic [DATA_W-1:0]  rd_data;

  // Slot examination
  logic               cur_used;
  logic               cur_tomb;
  logic               cur_empty;
  logic               hit;
  logic               done;
  logic               free_valid;
  logic               free_empty;
  logic [IDX_W-1:0]   free_addr;
  logic               over_limit;
  logic               out_free;

  // Sequencer controls
  logic               step;
  logic               fin;
  logic               start_ld;
  logic [IDX_W-1:0]   start_idx;
  logic               cnt_inc;
  logic               res_ok;
  logic               res_full;
  logic [DATA_W-1:0]  res_rval;

  oaht_slot_store #(
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr      (wr),
    .rd_stat (rd_stat),
    .rd_key  (rd_key),
    .rd_data (rd_data)
  );

  assign cfg_ready = 1'b1;

  // Remainder estimate is below three times the capacity; fold it down
  assign mod_diff = hash_r - mp;
  always_comb begin
    priority if (mod_diff >= CAP2X) begin
      mod_rem = mod_diff - CAP2X;
    end else if (mod_diff >= CAP32) begin
      mod_rem = mod_diff - CAP32;
    end else begin
      mod_rem = mod_diff;
    end
  end

  assign idx_inc = (idx == LAST) ? '0 : idx + 1'b1;

  // Classify the slot that was read last cycle
  assign cur_used   = (rd_stat == ST_USED);
  assign cur_tomb   = (rd_stat == ST_TOMB);
  assign cur_empty  = !cur_used && !cur_tomb;
  assign hit        = cur_used && (rd_key == key);
  assign done       = hit || cur_empty || (n == LAST);
  // First tombstone wins; else the empty slot that stopped the walk
  assign free_valid = tomb_found || cur_tomb || cur_empty;
  assign free_empty = !tomb_found && cur_empty;
  assign free_addr  = tomb_found ? tomb_idx : idx;
  assign over_limit = ({1'b0, cnt} + 1'b1) > (CNT_W + 1)'(load_limit);
  assign out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    rd_addr    = idx;
    wr_addr    = idx;
    wr         = '0;
    step       = 1'b0;
    fin        = 1'b0;
    start_ld   = 1'b0;
    start_idx  = mod_rem[IDX_W-1:0];
    cnt_inc    = 1'b0;
    res_ok     = 1'b0;
    res_full   = 1'b0;
    res_rval   = '0;
    unique case (state)
      S_CLEAR: begin
        wr_addr    = clr_idx;
        wr.stat_we = 1'b1;
        wr.stat    = ST_EMPTY;
        if (clr_idx == LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = key_hash[IDX_W-1:0];
        if (in_valid) begin
          if (IS_POW2) begin
            start_ld   = 1'b1;
            start_idx  = key_hash[IDX_W-1:0];
            state_next = S_PROBE;
          end else begin
            state_next = S_MOD1;
          end
        end
      end
      S_MOD1: begin
        state_next = S_MOD2;
      end
      S_MOD2: begin
        state_next = S_MOD3;
      end
      S_MOD3: begin
        rd_addr    = mod_rem[IDX_W-1:0];
        start_ld   = 1'b1;
        state_next = S_PROBE;
      end
      S_PROBE: begin
        if (!done) begin
          // advance to the next slot, wrapping
          step    = 1'b1;
          rd_addr = idx_inc;
        end else if (out_free) begin
          fin        = 1'b1;
          state_next = S_IDLE;
          unique case (op)
            FN_SET: begin
              if (hit) begin
                wr.kd_we = 1'b1;
                wr.key   = key;
                wr.data  = wval;
              end else if (!free_valid || (free_empty && over_limit)) begin
                res_full = 1'b1;
              end else begin
                wr_addr    = free_addr;
                wr.stat_we = 1'b1;
                wr.stat    = ST_USED;
                wr.kd_we   = 1'b1;
                wr.key     = key;
                wr.data    = wval;
                res_ok     = 1'b1;
                cnt_inc    = free_empty;
              end
            end
            FN_GET: begin
              if (hit && (cnt != '0)) begin
                res_ok   = 1'b1;
                res_rval = rd_data;
              end
            end
            FN_DEL: begin
              if (hit) begin
                wr.stat_we = 1'b1;
                wr.stat    = ST_TOMB;
                res_ok     = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end else begin
          // hold: response register still occupied, keep re-reading this slot
          rd_addr = idx;
        end
      end
    endcase
  end

  // Request capture and start-slot reduction
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op     <= func;
      key    <= key_id;
      wval   <= write_value;
      hash_r <= key_hash;
    end
    mq <= HASH_W'((64'(hash_r) * 64'(RECIP)) >> 32);
    mp <= HASH_W'(mq * CAP32);
  end

  // Probe walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tomb_found <= 1'b0;
    end else if (start_ld) begin
      tomb_found <= 1'b0;
    end else if (step && cur_tomb) begin
      tomb_found <= 1'b1;
    end
    if (start_ld) begin
      idx <= start_idx;
      n   <= '0;
    end else if (step) begin
      idx <= idx_inc;
      n   <= n + 1'b1;
      if (cur_tomb && !tomb_found) begin
        tomb_idx <= idx;
      end
    end
  end

  // Clear sweep, occupancy and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx    <= '0;
      cnt        <= '0;
      load_limit <= LIMIT_RESET;
    end else begin
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (cnt_inc) begin
        cnt <= cnt + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        load_limit <= cfg_data;
      end
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (fin) begin
      ok         <= res_ok;
      read_value <= res_rval;
      full_res   <= res_full;
    end
  end

  a_ok_full_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(ok && full_res))
    else $error("ok and full_res both set");

  a_resp_from_probe: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_PROBE)
    else $error("response loaded outside probe");

  a_write_window: assert property (@(posedge clk) disable iff (rst)
    (wr.stat_we || wr.kd_we) |-> (state == S_CLEAR || fin))
    else $error("slot write outside clear sweep or finish");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    cnt_inc |-> ((CNT_W + 1)'(cnt) < (CNT_W + 1)'(load_limit)))
    else $error("occupancy grows past load limit");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state != S_IDLE)
    else $error("request accepted but sequencer stayed idle");

endmodule

// ===== rtl/oaht_slot_store.sv =====
`timescale 1ns / 1ps
module oaht_slot_store #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                          clk,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  oaht_pkg::slot_wr_t            wr,
  output oaht_pkg::slot_stat_t          rd_stat,
  output logic [oaht_pkg::KEY_W-1:0]    rd_key,
  output logic [oaht_pkg::DATA_W-1:0]   rd_data
);
  import oaht_pkg::*;

  slot_stat_t        stat_mem [DEPTH];
  logic [KEY_W-1:0]  key_mem  [DEPTH];
  logic [DATA_W-1:0] data_mem [DEPTH];

  // Status memory: cleared by the sweep after reset
  always_ff @(posedge clk) begin
    if (wr.stat_we) begin
      stat_mem[wr_addr] <= wr.stat;
    end
    rd_stat <= stat_mem[rd_addr];
  end

  // Key and value memory: read every cycle, used only where status says used
  always_ff @(posedge clk) begin
    if (wr.kd_we) begin
      key_mem[wr_addr]  <= wr.key;
      data_mem[wr_addr] <= wr.data;
    end
    rd_key  <= key_mem[rd_addr];
    rd_data <= data_mem[rd_addr];
  end

endmodule
